// File: src/mmc_pkg.sv
// mmc_pkg: shared types and constants for the matrix multiply core
// used by mmc_ctrl, mmc_datapath and matrix_multiply_core
// no dependencies
package mmc_pkg;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;
	localparam int VAL_W  = 32;
	localparam int PROD_W = 2 * VAL_W;
	localparam int REG_W  = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	localparam logic [REG_W-1:0] REG_NUM_ROWS  = 2'd0;
	localparam logic [REG_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [REG_W-1:0] REG_NUM_COLS  = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// controller to datapath
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd_valid;
		logic             first_k;
		logic             last_k;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] k;
		logic             last;
	} mmc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic res_load;
	} mmc_stat_t;

endpackage

// File: src/mmc_ram.sv
// mmc_ram: generic single write, single read RAM with registered read data
// no dependencies
module mmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/mmc_ctrl.sv
// mmc_ctrl: dimension registers and sequencer for loads and the product walk
// depends on mmc_pkg
module mmc_ctrl #(
	parameter int MAX_DIM = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [mmc_pkg::REG_W-1:0]  cfg_index,
	input  logic [mmc_pkg::DIM_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mmc_pkg::CMD_W-1:0]  in_cmd,
	output mmc_pkg::mmc_cmd_t          cmd,
	input  mmc_pkg::mmc_stat_t         stat
);

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;

	localparam logic [mmc_pkg::DIM_W-1:0] DIM_MAX = mmc_pkg::DIM_W'(MAX_DIM);
	localparam logic [mmc_pkg::DIM_W-1:0] DIM_ONE = mmc_pkg::DIM_W'(1);

	state_t                       state_q;
	logic [mmc_pkg::DIM_W-1:0]    rows_q, inner_q, cols_q;
	logic [mmc_pkg::IDX_W-1:0]    r_q, c_q, k_q;
	logic [mmc_pkg::DIM_W-1:0]    nr, nk, nc;
	logic                         r_last, c_last, k_last, issue;

	function automatic logic [mmc_pkg::DIM_W-1:0] eff_dim(input logic [mmc_pkg::DIM_W-1:0] v);
		logic [mmc_pkg::DIM_W-1:0] d;
		if (v == '0) begin
			d = DIM_ONE;
		end else if (v > DIM_MAX) begin
			d = DIM_MAX;
		end else begin
			d = v;
		end
		return d;
	endfunction

	assign nr = eff_dim(rows_q);
	assign nk = eff_dim(inner_q);
	assign nc = eff_dim(cols_q);

	assign r_last = mmc_pkg::DIM_W'(r_q) == nr - DIM_ONE;
	assign c_last = mmc_pkg::DIM_W'(c_q) == nc - DIM_ONE;
	assign k_last = mmc_pkg::DIM_W'(k_q) == nk - DIM_ONE;

	assign in_ready = state_q == ST_IDLE;
	// a new element starts only once the output register can take its result
	assign issue = state_q == ST_ISSUE && (k_q != '0 || stat.out_free);

	always_comb begin
		cmd          = '0;
		cmd.wr_a     = in_ready && in_valid && in_cmd == mmc_pkg::CMD_LOAD_A;
		cmd.wr_b     = in_ready && in_valid && in_cmd == mmc_pkg::CMD_LOAD_B;
		cmd.rd_valid = issue;
		cmd.first_k  = k_q == '0;
		cmd.last_k   = k_last;
		cmd.r        = r_q;
		cmd.c        = c_q;
		cmd.k        = k_q;
		cmd.last     = r_last && c_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q  <= mmc_pkg::DIM_RESET;
			inner_q <= mmc_pkg::DIM_RESET;
			cols_q  <= mmc_pkg::DIM_RESET;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					mmc_pkg::REG_NUM_ROWS:  rows_q  <= cfg_data;
					mmc_pkg::REG_INNER_DIM: inner_q <= cfg_data;
					mmc_pkg::REG_NUM_COLS:  cols_q  <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_cmd == mmc_pkg::CMD_COMPUTE) begin
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (issue) begin
						if (k_last) begin
							k_q     <= '0;
							state_q <= ST_DRAIN;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (stat.res_load) begin
						if (r_last && c_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ISSUE;
							if (c_last) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_start_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_valid && cmd.first_k |-> stat.out_free)
		else $error("element started while output register occupied");
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> mmc_pkg::DIM_W'(k_q) < nk)
		else $error("inner index beyond inner dimension");
	a_no_result_outside_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_load |-> state_q == ST_DRAIN)
		else $error("result landed outside drain");
`endif

endmodule

// File: src/mmc_datapath.sv
// mmc_datapath: A and B stores, multiply and accumulate pipeline,
// floor shift with saturation and the output register
// depends on mmc_pkg and mmc_ram
module mmc_datapath #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mmc_pkg::mmc_cmd_t                 cmd,
	output mmc_pkg::mmc_stat_t                stat,
	input  logic [mmc_pkg::IDX_W-1:0]         ld_row,
	input  logic [mmc_pkg::IDX_W-1:0]         ld_col,
	input  logic [mmc_pkg::VAL_W-1:0]         ld_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mmc_pkg::IDX_W-1:0]         out_row,
	output logic [mmc_pkg::IDX_W-1:0]         out_col,
	output logic [mmc_pkg::VAL_W-1:0]         out_value,
	output logic                              out_sat,
	output logic                              out_last
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int ACC_W = mmc_pkg::PROD_W + $clog2(MAX_DIM);
	localparam int HI_W  = ACC_W - mmc_pkg::VAL_W + 1;
	localparam logic [mmc_pkg::IDX_W:0] DIM_LIM = (mmc_pkg::IDX_W + 1)'(MAX_DIM);

	logic [AW-1:0]                       wr_addr, a_rd_addr, b_rd_addr;
	logic                                wr_ok;
	logic [mmc_pkg::VAL_W-1:0]           a_rd, b_rd;
	logic                                valid_s1, first_s1, last_s1;
	logic                                valid_s2, first_s2, last_s2;
	logic signed [mmc_pkg::PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]             acc_q, shifted;
	logic                                done_s3;
	logic [HI_W-1:0]                     hi;
	logic                                clip;
	logic [mmc_pkg::VAL_W-1:0]           res;
	logic                                out_valid_q, out_sat_q, out_last_q;
	logic [mmc_pkg::IDX_W-1:0]           out_row_q, out_col_q;
	logic [mmc_pkg::VAL_W-1:0]           out_value_q;

	assign wr_ok     = {1'b0, ld_row} < DIM_LIM && {1'b0, ld_col} < DIM_LIM;
	assign wr_addr   = AW'(MAX_DIM * ld_row + ld_col);
	assign a_rd_addr = AW'(MAX_DIM * cmd.r + cmd.k);
	assign b_rd_addr = AW'(MAX_DIM * cmd.k + cmd.c);

	mmc_ram #(.WIDTH(mmc_pkg::VAL_W), .DEPTH(DEPTH)) u_a_store (
		.clk     (clk),
		.wr_en   (cmd.wr_a && wr_ok),
		.wr_addr (wr_addr),
		.wr_data (ld_value),
		.rd_en   (cmd.rd_valid),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd)
	);

	mmc_ram #(.WIDTH(mmc_pkg::VAL_W), .DEPTH(DEPTH)) u_b_store (
		.clk     (clk),
		.wr_en   (cmd.wr_b && wr_ok),
		.wr_addr (wr_addr),
		.wr_data (ld_value),
		.rd_en   (cmd.rd_valid),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_valid;
			valid_s2 <= valid_s1;
			done_s3  <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first_k;
		last_s1  <= cmd.last_k;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= $signed(a_rd) * $signed(b_rd);
		if (valid_s2) begin
			acc_q <= (first_s2 ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);
		end
	end

	// floor shift of the exact sum, then clip to 32 bits
	assign shifted = acc_q >>> FRAC_BITS;
	assign hi      = shifted[ACC_W-1:mmc_pkg::VAL_W-1];
	assign clip    = !((&hi) || !(|hi));
	always_comb begin
		if (!clip) begin
			res = shifted[mmc_pkg::VAL_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			res = {1'b1, {(mmc_pkg::VAL_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(mmc_pkg::VAL_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s3) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s3) begin
			out_row_q   <= cmd.r;
			out_col_q   <= cmd.c;
			out_value_q <= res;
			out_sat_q   <= clip;
			out_last_q  <= cmd.last;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.res_load = done_s3;

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign out_sat   = out_sat_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done_s3 |-> (!out_valid_q || out_ready))
		else $error("result overwrote an untaken transfer");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		done_s3 |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

// File: src/matrix_multiply_core.sv
// matrix_multiply_core: dense Q16.16 matrix product C = A x B
// depends on mmc_pkg, mmc_ctrl, mmc_datapath, mmc_ram
//
// usage:
//   cfg port: cfg_wr_en, cfg_index (0 num_rows, 1 inner_dim, 2 num_cols),
//   cfg_data; write only while the core is idle. all three reset to 8,
//   0 acts as 1 and values above MAX_DIM act as MAX_DIM
//   input stream: s_tuser holds the command (0 load A, 1 load B, 2 compute)
//   a load transfer writes one element; loads with an index of MAX_DIM
//   or more are dropped
//   compute emits num_rows*num_cols results in row-major order on the output
//   stream, m_tlast on the final one, m_tuser set when a result was clipped
//   each result passes through reads, multiply, acc and the output register;
//   the next element is issued once the previous result has been loaded
//   s_tready stays low while a product is being walked
//   a stalled receiver holds the output register; the next element starts
//   only when that register is free, so nothing is lost
//   reset returns control to idle and all three dimensions to 8; the stores
//   are not cleared and must be loaded before use
module matrix_multiply_core #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // row_index, col_index, element_value, zero pad
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_row, out_col, product_value, zero pad
	output logic [0:0]  m_tuser,   // saturated
	output logic        m_tlast
);

	mmc_pkg::mmc_cmd_t              cmd;
	mmc_pkg::mmc_stat_t             stat;
	logic [mmc_pkg::IDX_W-1:0]      out_row, out_col;
	logic [mmc_pkg::VAL_W-1:0]      out_value;
	logic                           out_sat;

	mmc_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

	mmc_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.ld_row    (s_tdata[2:0]),
		.ld_col    (s_tdata[5:3]),
		.ld_value  (s_tdata[37:6]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.out_sat   (out_sat),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, out_value, out_col, out_row};
	assign m_tuser = out_sat;

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for matrix_multiply_core (Q16.16 C = A x B, row-major results)
// directed table, then random load/compute rounds; every result transfer checked in order
// depends on mmc_pkg and matrix_multiply_core
module tb;

	localparam int DIM_MAX     = 8;
	localparam int FRAC        = 16;
	localparam int RAND_ITEMS  = 220;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 16;
	localparam int LIMIT       = 2_000_000;
	localparam logic [mmc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [69:0] Q_MAX = 70'sh7FFF_FFFF;
	localparam logic signed [69:0] Q_MIN = -70'sh8000_0000;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic        sat;
		logic        last;
	} c_elem_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_XFER, ROW_CHECKED} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  code;
		logic [2:0]  r;
		logic [2:0]  c;
		logic [31:0] v;
		logic [31:0] want;
		logic        want_sat;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // row_index, col_index, element_value, zero pad
	logic [1:0]  s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // out_row, out_col, product_value, zero pad
	logic [0:0]  m_tuser;   // saturated
	logic        m_tlast;

	logic signed [31:0] a_mem [DIM_MAX*DIM_MAX];
	logic signed [31:0] b_mem [DIM_MAX*DIM_MAX];
	bit                 a_ok  [DIM_MAX*DIM_MAX];
	bit                 b_ok  [DIM_MAX*DIM_MAX];
	logic [3:0]         rows_reg  = mmc_pkg::DIM_RESET;
	logic [3:0]         inner_reg = mmc_pkg::DIM_RESET;
	logic [3:0]         cols_reg  = mmc_pkg::DIM_RESET;
	c_elem_t            c_elems_q [$];
	int                 err_cnt;
	int                 cycle_cnt;
	int                 src_idle_pct;
	int                 sink_idle_pct;
	bit                 hold_req;

	// a compute at the reset dimensions, extremes and special cases at 1x1x1, then out-of-range dimension settings
	dir_row_t dir_tab [33] = '{
		'{ROW_XFER,    mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h0,         1'b0},
		'{ROW_CFG,     mmc_pkg::REG_NUM_ROWS,  3'd0, 3'd0, 32'd1,         32'h0,         1'b0},
		'{ROW_CFG,     mmc_pkg::REG_INNER_DIM, 3'd0, 3'd0, 32'd1,         32'h0,         1'b0},
		'{ROW_CFG,     mmc_pkg::REG_NUM_COLS,  3'd0, 3'd0, 32'd1,         32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_A,    3'd0, 3'd0, 32'h0001_0000, 32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_B,    3'd0, 3'd0, 32'h0002_0000, 32'h0,         1'b0},
		'{ROW_CHECKED, mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h0002_0000, 1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_A,    3'd0, 3'd0, 32'h7FFF_FFFF, 32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_B,    3'd0, 3'd0, 32'h7FFF_FFFF, 32'h0,         1'b0},
		'{ROW_CHECKED, mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h7FFF_FFFF, 1'b1},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_A,    3'd0, 3'd0, 32'h8000_0000, 32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_B,    3'd0, 3'd0, 32'h8000_0000, 32'h0,         1'b0},
		'{ROW_CHECKED, mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h7FFF_FFFF, 1'b1},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_B,    3'd0, 3'd0, 32'h7FFF_FFFF, 32'h0,         1'b0},
		'{ROW_CHECKED, mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h8000_0000, 1'b1},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_A,    3'd0, 3'd0, 32'hFFFF_FFFF, 32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_B,    3'd0, 3'd0, 32'h0000_0001, 32'h0,         1'b0},
		'{ROW_CHECKED, mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'hFFFF_FFFF, 1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_A,    3'd0, 3'd0, 32'h0001_0000, 32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_B,    3'd0, 3'd0, 32'h8000_0000, 32'h0,         1'b0},
		'{ROW_CHECKED, mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h8000_0000, 1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_A,    3'd7, 3'd7, 32'hFFFF_FFFF, 32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_LOAD_B,    3'd7, 3'd7, 32'h7FFF_FFFF, 32'h0,         1'b0},
		'{ROW_XFER,    CMD_UNUSED,             3'd7, 3'd7, 32'hFFFF_FFFF, 32'h0,         1'b0},
		'{ROW_CHECKED, mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h8000_0000, 1'b0},
		'{ROW_CFG,     mmc_pkg::REG_NUM_ROWS,  3'd0, 3'd0, 32'd0,         32'h0,         1'b0},
		'{ROW_CFG,     mmc_pkg::REG_INNER_DIM, 3'd0, 3'd0, 32'd15,        32'h0,         1'b0},
		'{ROW_CFG,     mmc_pkg::REG_NUM_COLS,  3'd0, 3'd0, 32'd0,         32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h0,         1'b0},
		'{ROW_CFG,     mmc_pkg::REG_NUM_ROWS,  3'd0, 3'd0, 32'd15,        32'h0,         1'b0},
		'{ROW_CFG,     mmc_pkg::REG_INNER_DIM, 3'd0, 3'd0, 32'd0,         32'h0,         1'b0},
		'{ROW_CFG,     mmc_pkg::REG_NUM_COLS,  3'd0, 3'd0, 32'd9,         32'h0,         1'b0},
		'{ROW_XFER,    mmc_pkg::CMD_COMPUTE,   3'd0, 3'd0, 32'h0,         32'h0,         1'b0}
	};

	matrix_multiply_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim(input logic [3:0] raw);
		if (raw == 4'd0)
			return 1;
		if (raw > DIM_MAX)
			return DIM_MAX;
		return int'(raw);
	endfunction

	// exact sum of products, floor shift, saturate; pushes every C element in row-major order
	function automatic void compute_product();
		int nr, nk, nc;
		logic signed [69:0] acc;
		c_elem_t e;
		nr = eff_dim(rows_reg);
		nk = eff_dim(inner_reg);
		nc = eff_dim(cols_reg);
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				acc = '0;
				for (int k = 0; k < nk; k++)
					acc = acc + a_mem[r*DIM_MAX+k] * b_mem[k*DIM_MAX+c];
				acc = acc >>> FRAC;
				e.row  = 3'(r);
				e.col  = 3'(c);
				e.last = (r == nr - 1) && (c == nc - 1);
				if (acc > Q_MAX) begin
					e.value = 32'h7FFF_FFFF;
					e.sat   = 1'b1;
				end else if (acc < Q_MIN) begin
					e.value = 32'h8000_0000;
					e.sat   = 1'b1;
				end else begin
					e.value = acc[31:0];
					e.sat   = 1'b0;
				end
				c_elems_q.push_back(e);
			end
		end
	endfunction

	function automatic void apply_item(input logic [1:0] cmd, input logic [2:0] r,
			input logic [2:0] c, input logic [31:0] v);
		case (cmd)
			mmc_pkg::CMD_LOAD_A: begin
				a_mem[r*DIM_MAX+c] = v;
				a_ok[r*DIM_MAX+c]  = 1'b1;
			end
			mmc_pkg::CMD_LOAD_B: begin
				b_mem[r*DIM_MAX+c] = v;
				b_ok[r*DIM_MAX+c]  = 1'b1;
			end
			mmc_pkg::CMD_COMPUTE: compute_product();
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] rand_elem();
		logic [31:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h0;
				endcase
			end
			1, 2, 3: v = $urandom;
			default: begin
				// up to +-4.0
				v = $urandom_range(32'h0004_0000);
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [3:0] pick_dim();
		if ($urandom_range(99) < 75)
			return 4'($urandom_range(4, 1));
		return 4'($urandom_range(15));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_cnt++;
		$display("tb: %s mismatch at cycle %0d: got %h, want %h", what, cycle_cnt, got, want);
	endtask

	// one input transfer; returns at the accepting rising edge
	task automatic send_item(input logic [1:0] cmd, input logic [2:0] r, input logic [2:0] c,
			input logic [31:0] v, input bit use_fixed = 1'b0, input c_elem_t fixed = '0);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, v, c, r};
		do
			@(posedge clk);
		while (!s_tready);
		if (use_fixed)
			c_elems_q.push_back(fixed);
		else
			apply_item(cmd, r, c, v);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (c_elems_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [3:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			mmc_pkg::REG_NUM_ROWS:  rows_reg  = val;
			mmc_pkg::REG_INNER_DIM: inner_reg = val;
			mmc_pkg::REG_NUM_COLS:  cols_reg  = val;
			default: ;
		endcase
	endtask

	// stores start undefined, so every entry a compute will read gets loaded first
	task automatic load_missing();
		int nr, nk, nc;
		nr = eff_dim(rows_reg);
		nk = eff_dim(inner_reg);
		nc = eff_dim(cols_reg);
		for (int r = 0; r < nr; r++)
			for (int k = 0; k < nk; k++)
				if (!a_ok[r*DIM_MAX+k])
					send_item(mmc_pkg::CMD_LOAD_A, 3'(r), 3'(k), rand_elem());
		for (int k = 0; k < nk; k++)
			for (int c = 0; c < nc; c++)
				if (!b_ok[k*DIM_MAX+c])
					send_item(mmc_pkg::CMD_LOAD_B, 3'(k), 3'(c), rand_elem());
	endtask

	always @(posedge clk) begin : result_check
		c_elem_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (c_elems_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[37:6], 32'h0);
			end else begin
				want = c_elems_q.pop_front();
				if (m_tdata[2:0] != want.row)
					report_mismatch("out_row", 32'(m_tdata[2:0]), 32'(want.row));
				if (m_tdata[5:3] != want.col)
					report_mismatch("out_col", 32'(m_tdata[5:3]), 32'(want.col));
				if (m_tdata[37:6] != want.value)
					report_mismatch("product_value", m_tdata[37:6], want.value);
				if (m_tuser[0] != want.sat)
					report_mismatch("saturated", 32'(m_tuser[0]), 32'(want.sat));
				if (m_tlast != want.last)
					report_mismatch("last", 32'(m_tlast), 32'(want.last));
			end
		end
	end

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					m_tready <= 1'b0;
					@(negedge clk);
				end
			end
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		int n_rand;
		int n;
		int nr, nk, nc;
		bit stall_round;
		bit hold_done;
		logic [1:0] cmd;
		logic [2:0] r, c;
		c_elem_t fixed;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		src_idle_pct  = 32;
		sink_idle_pct = 55;
		n_rand        = 0;
		hold_done     = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			case (dir_tab[i].kind)
				ROW_CFG: begin
					wait_drain();
					cfg_write(dir_tab[i].code, dir_tab[i].v[3:0]);
				end
				ROW_XFER: begin
					if (dir_tab[i].code == mmc_pkg::CMD_COMPUTE)
						load_missing();
					send_item(dir_tab[i].code, dir_tab[i].r, dir_tab[i].c, dir_tab[i].v);
				end
				ROW_CHECKED: begin
					fixed = '{3'd0, 3'd0, dir_tab[i].want, dir_tab[i].want_sat, 1'b1};
					send_item(mmc_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, fixed);
				end
				default: ;
			endcase
		end

		// random rounds: optional new dimensions, loads mostly inside them, then a product
		while (n_rand < RAND_ITEMS) begin
			if (n_rand < RAND_ITEMS / 3) begin
				src_idle_pct  = 32;
				sink_idle_pct = 55;
			end else if (n_rand < 2 * RAND_ITEMS / 3) begin
				src_idle_pct  = 55;
				sink_idle_pct = 32;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			stall_round = (src_idle_pct == 0) && !hold_done;
			wait_drain();
			if (stall_round) begin
				cfg_write(mmc_pkg::REG_NUM_ROWS, 4'd8);
				cfg_write(mmc_pkg::REG_INNER_DIM, 4'd8);
				cfg_write(mmc_pkg::REG_NUM_COLS, 4'd8);
			end else if ($urandom_range(99) < 60) begin
				if ($urandom_range(1))
					cfg_write(mmc_pkg::REG_NUM_ROWS, pick_dim());
				if ($urandom_range(1))
					cfg_write(mmc_pkg::REG_INNER_DIM, pick_dim());
				if ($urandom_range(1))
					cfg_write(mmc_pkg::REG_NUM_COLS, pick_dim());
			end
			nr = eff_dim(rows_reg);
			nk = eff_dim(inner_reg);
			nc = eff_dim(cols_reg);

			n = $urandom_range(10, 1);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(19))
					0: cmd = CMD_UNUSED;
					1, 2, 3, 4, 5, 6, 7, 8, 9: cmd = mmc_pkg::CMD_LOAD_A;
					default: cmd = mmc_pkg::CMD_LOAD_B;
				endcase
				if ($urandom_range(99) < 80 && cmd == mmc_pkg::CMD_LOAD_A) begin
					r = 3'($urandom_range(nr - 1));
					c = 3'($urandom_range(nk - 1));
				end else if ($urandom_range(99) < 80 && cmd == mmc_pkg::CMD_LOAD_B) begin
					r = 3'($urandom_range(nk - 1));
					c = 3'($urandom_range(nc - 1));
				end else begin
					r = 3'($urandom_range(7));
					c = 3'($urandom_range(7));
				end
				send_item(cmd, r, c, rand_elem());
				if (cmd != CMD_UNUSED)
					n_rand++;
			end

			load_missing();
			if (stall_round)
				hold_req = 1'b1;
			send_item(mmc_pkg::CMD_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
			n_rand++;
			if ($urandom_range(99) < 10) begin
				send_item(mmc_pkg::CMD_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
				n_rand++;
			end

			// loads queued behind the product wait on s_tready
			if (stall_round || $urandom_range(99) < 25) begin
				n = $urandom_range(8, 3);
				for (int i = 0; i < n; i++) begin
					send_item($urandom_range(1) ? mmc_pkg::CMD_LOAD_A : mmc_pkg::CMD_LOAD_B,
						3'($urandom_range(7)), 3'($urandom_range(7)), rand_elem());
					n_rand++;
				end
			end
			if (stall_round)
				hold_done = 1'b1;
		end

		wait_drain();
		if (err_cnt == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
